### rtl/core/wav_header_chunk_parser_core_defines.svh
// Assertion macros for the WAV header chunk parser.
// Used by the top level only; no other dependencies.
`ifndef WAV_HEADER_CHUNK_PARSER_CORE_DEFINES_SVH
`define WAV_HEADER_CHUNK_PARSER_CORE_DEFINES_SVH
// Assert that prop holds at every clock edge outside reset.
`define WHP_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Assert that prop holds at every clock edge, reset included.
`define WHP_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

### rtl/core/whp_pkg.sv
// Shared constants and types for the WAV header chunk parser.
// No dependencies.
`default_nettype none
package whp_pkg;
  localparam logic [3:0] ST_OK       = 4'd0;
  localparam logic [3:0] ST_SHORT    = 4'd1;
  localparam logic [3:0] ST_MAGIC    = 4'd2;
  localparam logic [3:0] ST_OVERRUN  = 4'd3;
  localparam logic [3:0] ST_FMT_SIZE = 4'd4;
  localparam logic [3:0] ST_TAG      = 4'd5;
  localparam logic [3:0] ST_SIZES    = 4'd6;
  localparam logic [3:0] ST_CHANNELS = 4'd7;
  localparam logic [3:0] ST_WIDTH    = 4'd8;
  localparam logic [3:0] ST_NO_FMT   = 4'd9;
  localparam logic [3:0] ST_NO_FACT  = 4'd10;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_FACT = 32'h7463_6166;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [15:0] FT_PCM   = 16'h0001;
  localparam logic [15:0] FT_FLOAT = 16'h0003;
  localparam logic [15:0] FT_ALAW  = 16'h0006;
  localparam logic [15:0] FT_MULAW = 16'h0007;
  localparam logic [15:0] FT_EXT   = 16'hFFFE;

  localparam logic [2:0] SF_U8    = 3'd0;
  localparam logic [2:0] SF_S16   = 3'd1;
  localparam logic [2:0] SF_F32   = 3'd2;
  localparam logic [2:0] SF_F64   = 3'd3;
  localparam logic [2:0] SF_ALAW  = 3'd4;
  localparam logic [2:0] SF_ULAW  = 3'd5;

  // Divider handshake between the sequencer and the shared unit.
  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [31:0] quotient;
  } div_rsp_t;
endpackage
`default_nettype wire

### rtl/core/whp_divider.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on whp_pkg.
`default_nettype none
module whp_divider
  import whp_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);
  logic [31:0] quo_q, quo_d, den_q, den_d;
  logic [32:0] rem_q, rem_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [32:0] trial;

  always_comb begin
    quo_d  = quo_q;
    den_d  = den_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[31:0], quo_q[31]} - {1'b0, den_q};
    if (req_i.start) begin
      quo_d  = req_i.dividend;
      den_d  = req_i.divisor;
      rem_d  = '0;
      cnt_d  = 6'd32;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[32]) begin
        rem_d = trial;
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = {rem_q[31:0], quo_q[31]};
        quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;
endmodule
`default_nettype wire

### rtl/core/wav_header_chunk_parser_core.sv
// WAV header chunk parser: consumes a RIFF/WAVE file one byte per word on the
// slave stream and emits one summary word on the master stream at end of file.
// Depends on whp_pkg, whp_divider and the defines header.
//
// Bytes are taken one per cycle, except while the divider runs or a second
// end-of-file waits. When a fmt chunk body ends and its size and tag pass,
// the parser runs two divisions through a shared serial divider (byte rate
// over channels*rate, then block align over channels); no byte is taken
// until both are done, and bits/8 is a shift. If the fmt chunk ends on the
// final byte of the file, the summary word follows the second division.
// Everything else moves at one byte per cycle. The result word waits in an
// output register; the next file's bytes are taken meanwhile, but a second
// end-of-file waits until the first result has been taken. First error
// sticks; error results carry only the status, with all other fields zero.
`default_nettype none
`include "wav_header_chunk_parser_core_defines.svh"
module wav_header_chunk_parser_core
  import whp_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [7:0]   s_axis_tdata,   // [7:0] data_byte
  input  wire logic         s_axis_tlast,   // end_of_file
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // [3:0] status, [35:4] rate, [36] stereo, [39:37] sample_format,
  // [40] data_found, [72:41] data_length, [104:73] data_offset, [111:105] zero
  output logic [111:0]      m_axis_tdata
);
  localparam logic [1:0] PH_RIFF = 2'd0;
  localparam logic [1:0] PH_HEAD = 2'd1;
  localparam logic [1:0] PH_BODY = 2'd2;

  localparam logic [1:0] SQ_IDLE = 2'd0;
  localparam logic [1:0] SQ_DIV1 = 2'd1;
  localparam logic [1:0] SQ_DIV2 = 2'd2;

  logic [1:0]  phase_q, phase_d, sq_q, sq_d;
  logic [3:0]  hcnt_q, hcnt_d, err_q, err_d;
  logic [31:0] tag_q, tag_d, len_q, len_d, body_q, body_d, off_q, off_d;
  logic [63:0] ff_q, ff_d, fr_q, fr_d;
  logic [2:0]  seen_q, seen_d;
  logic [15:0] lft_q, lft_d;
  logic [35:0] res_q, res_d;
  logic [63:0] dl_q, dl_d;
  logic [31:0] bps_q, bps_d;
  logic        ov_q, ov_d;
  logic        eof_q, eof_d;
  logic [111:0] od_q, od_d;
  div_req_t    dreq;
  div_rsp_t    drsp;
  logic        acc;

  whp_divider u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  wire [15:0] f_tag = ff_q[15:0];
  wire [15:0] f_ch  = ff_q[31:16];
  wire [31:0] f_rate = ff_q[63:32];
  wire [15:0] f_align = fr_q[47:32];
  wire [15:0] f_bits = fr_q[63:48];

  assign s_axis_tready = (sq_q == SQ_IDLE) && !(s_axis_tlast && ov_q && !m_axis_tready);
  assign acc = s_axis_tvalid && s_axis_tready;

  always_comb begin
    logic [3:0]  n, st;
    logic [2:0]  fmt;
    logic        fin, beg, emit;
    logic [7:0]  b;
    phase_d = phase_q; hcnt_d = hcnt_q; tag_d = tag_q; len_d = len_q;
    body_d = body_q; off_d = off_q; ff_d = ff_q; fr_d = fr_q; err_d = err_q;
    seen_d = seen_q; lft_d = lft_q; res_d = res_q; dl_d = dl_q; sq_d = sq_q;
    bps_d = bps_q; ov_d = ov_q && !m_axis_tready; od_d = od_q; eof_d = eof_q;
    dreq = '0; fin = 1'b0; beg = 1'b0; emit = 1'b0; fmt = SF_U8; st = ST_OK;
    b = s_axis_tdata; n = hcnt_q;
    case (sq_q)
      SQ_DIV1: begin
        if (drsp.done) begin
          bps_d = drsp.quotient;
          dreq.start = 1'b1;
          dreq.dividend = {16'd0, f_align};
          dreq.divisor = {16'd0, f_ch};
          sq_d = SQ_DIV2;
        end
      end
      SQ_DIV2: begin
        if (drsp.done) begin
          sq_d = SQ_IDLE;
          // compare bytes per sample against align/ch and bits/8
          if (bps_q != drsp.quotient || bps_q != {19'd0, f_bits[15:3]})
            err_d = ST_SIZES;
          else if (f_ch != 16'd1 && f_ch != 16'd2) err_d = ST_CHANNELS;
          else begin
            st = ST_OK;
            case (f_tag)
              FT_PCM: begin
                if (bps_q == 32'd1) fmt = SF_U8;
                else if (bps_q == 32'd2) fmt = SF_S16;
                else st = ST_WIDTH;
              end
              FT_FLOAT: begin
                if (bps_q == 32'd4) fmt = SF_F32;
                else if (bps_q == 32'd8) fmt = SF_F64;
                else st = ST_WIDTH;
              end
              FT_ALAW: begin
                if (bps_q == 32'd1) fmt = SF_ALAW; else st = ST_WIDTH;
              end
              FT_MULAW: begin
                if (bps_q == 32'd1) fmt = SF_ULAW; else st = ST_WIDTH;
              end
              default: st = ST_TAG;
            endcase
            if (st != ST_OK) err_d = st;
            else begin
              res_d = {fmt, f_ch == 16'd2, f_rate};
              lft_d = f_tag;
              seen_d[0] = 1'b1;
            end
          end
          // the file ended on the last fmt byte: send its word now
          if (eof_q) emit = 1'b1;
        end
      end
      default: begin
        if (acc) begin
          if (err_q == ST_OK) begin
            off_d = off_q + 32'd1;
            case (phase_q)
              PH_RIFF: begin
                if (n < 4'd4) tag_d[8*n[1:0] +: 8] = b;
                else if (n >= 4'd8) len_d[8*n[1:0] +: 8] = b;
                if (n == 4'd11) begin
                  if (tag_q != TAG_RIFF || {b, len_q[23:0]} != TAG_WAVE)
                    err_d = ST_MAGIC;
                  phase_d = PH_HEAD; hcnt_d = '0; tag_d = '0; len_d = '0;
                end else hcnt_d = n + 4'd1;
              end
              PH_HEAD: begin
                if (n < 4'd4) tag_d[8*n[1:0] +: 8] = b;
                else len_d[8*n[1:0] +: 8] = b;
                if (n == 4'd7) begin
                  hcnt_d = '0;
                  beg = 1'b1;
                end else hcnt_d = n + 4'd1;
              end
              default: begin
                if (body_q < 32'd8) ff_d[8*body_q[2:0] +: 8] = b;
                else if (body_q < 32'd16) fr_d[8*body_q[2:0] +: 8] = b;
                body_d = body_q + 32'd1;
                if ({1'b0, body_q} + 33'd1 >= {1'b0, len_q}) fin = 1'b1;
              end
            endcase
            if (beg) begin
              body_d = '0; ff_d = '0; fr_d = '0;
              if (tag_d == TAG_FACT) seen_d[1] = 1'b1;
              if (tag_d == TAG_DATA) begin
                seen_d[2] = 1'b1;
                dl_d = {off_d, len_d};
              end
              if (len_d == 32'd0) fin = 1'b1;
              else phase_d = PH_BODY;
            end
            if (fin) begin
              if (tag_d == TAG_FMT) begin
                // checks that need no division, then kick off the divider
                if (len_d != 32'd16 && len_d != 32'd18 && len_d != 32'd40)
                  err_d = ST_FMT_SIZE;
                else if (ff_d[15:0] != FT_PCM && ff_d[15:0] != FT_FLOAT &&
                         ff_d[15:0] != FT_ALAW && ff_d[15:0] != FT_MULAW &&
                         ff_d[15:0] != FT_EXT)
                  err_d = ST_TAG;
                else if (ff_d[15:0] != FT_PCM && len_d == 32'd16)
                  err_d = ST_FMT_SIZE;
                else if (32'(ff_d[63:32] * {16'd0, ff_d[31:16]}) == 32'd0)
                  err_d = ST_SIZES;
                else begin
                  dreq.start = 1'b1;
                  dreq.dividend = fr_d[31:0];
                  dreq.divisor = 32'(ff_d[63:32] * {16'd0, ff_d[31:16]});
                  sq_d = SQ_DIV1;
                end
              end
              phase_d = PH_HEAD; hcnt_d = '0; tag_d = '0; len_d = '0; body_d = '0;
            end
          end
          if (s_axis_tlast) begin
            // hold the word back while a fmt check is still dividing
            if (sq_d != SQ_IDLE) eof_d = 1'b1;
            else emit = 1'b1;
          end
        end
      end
    endcase
    // End of file: build the summary word and return the parse state to its reset values.
    if (emit) begin
      st = err_d;
      if (st == ST_OK) begin
        if (phase_d == PH_RIFF) st = ST_SHORT;
        else if (phase_d == PH_BODY) st = ST_OVERRUN;
        else if (!seen_d[0]) st = ST_NO_FMT;
        else if (lft_d != FT_PCM && !seen_d[1]) st = ST_NO_FACT;
      end
      if (st == ST_OK)
        od_d = {7'd0, dl_d[63:32], dl_d[31:0], seen_d[2], res_d, st};
      else od_d = {108'd0, st};
      ov_d = 1'b1; eof_d = 1'b0;
      phase_d = PH_RIFF; hcnt_d = '0; tag_d = '0; len_d = '0; body_d = '0;
      ff_d = '0; fr_d = '0; off_d = '0; err_d = ST_OK; seen_d = '0;
      lft_d = '0; res_d = '0; dl_d = '0;
    end
  end

  // Control and parse state; the output slot is free whenever eof_q is set,
  // since the final byte is only taken once any earlier word has gone.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_RIFF; hcnt_q <= '0; err_q <= ST_OK; seen_q <= '0;
      sq_q <= SQ_IDLE; ov_q <= 1'b0; eof_q <= 1'b0; off_q <= '0; body_q <= '0;
      tag_q <= '0; len_q <= '0; ff_q <= '0; fr_q <= '0; lft_q <= '0;
      res_q <= '0; dl_q <= '0;
    end else begin
      phase_q <= phase_d; hcnt_q <= hcnt_d; err_q <= err_d; seen_q <= seen_d;
      sq_q <= sq_d; ov_q <= ov_d; eof_q <= eof_d; off_q <= off_d; body_q <= body_d;
      tag_q <= tag_d; len_q <= len_d; ff_q <= ff_d; fr_q <= fr_d; lft_q <= lft_d;
      res_q <= res_d; dl_q <= dl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bps_q <= bps_d;
    od_q  <= od_d;
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = od_q;

  `WHP_ASSERT(a_no_take_while_div, clk_i, rst_ni, (sq_q != SQ_IDLE) |-> !s_axis_tready, "byte taken during fmt division")
  `WHP_ASSERT(a_div_busy, clk_i, rst_ni, (sq_q != SQ_IDLE) |-> (drsp.busy || drsp.done), "sequencer waits on an idle divider")
  `WHP_ASSERT(a_err_zero, clk_i, rst_ni, (m_axis_tvalid && m_axis_tdata[3:0] != ST_OK) |-> (m_axis_tdata[111:4] == '0), "error result carries data")
endmodule
`default_nettype wire
